/* hw/rtl/kwhm_pkg.sv */
// Package for the k-way heap merge core: field widths, item kinds,
// default sizes and the controller/datapath command and status words.
// No dependencies.
package kwhm_pkg;

	localparam int DEF_NUM_SOURCES = 8;
	localparam int DEF_LIST_DEPTH  = 64;

	localparam int OFF_W  = 63;
	localparam int LEN_W  = 32;
	localparam int SRC_W  = 3;
	localparam int MODE_W = 2;
	localparam int DATA_W = 104;

	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_START = 2'd1;
	localparam logic [MODE_W-1:0] MODE_POP   = 2'd2;

	typedef struct packed {
		logic load;
		logic scan_init;
		logic scan_step;
		logic build_init;
		logic bi_dec;
		logic sift_init_build;
		logic rd_k;
		logic cap_k;
		logic rd_l;
		logic cmp_l;
		logic rd_r;
		logic cmp_r;
		logic swap;
		logic pop_rd;
		logic pop_cap;
		logic emit;
		logic emit_empty;
	} kwhm_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic bi_zero;
		logic l_ok;
		logic r_ok;
		logic m_is_k;
		logic size_zero;
		logic out_busy;
	} kwhm_sts_t;

endpackage

/* hw/rtl/kwhm_datapath.sv */
// Datapath of the k-way heap merge core: element memory, list counters,
// heap slots, sift-down compare registers and the output register.
// Depends on kwhm_pkg.
module kwhm_datapath import kwhm_pkg::*; #(
	parameter int NUM_SOURCES = DEF_NUM_SOURCES,
	parameter int LIST_DEPTH  = DEF_LIST_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SRC_W-1:0]  in_source,
	input  logic [OFF_W-1:0]  in_offset,
	input  logic [LEN_W-1:0]  in_length,
	input  kwhm_cmd_t         cmd,
	output kwhm_sts_t         sts,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,
	output logic              m_tlast,
	output logic              m_tuser
);

	localparam int PW  = $clog2(NUM_SOURCES);
	localparam int SZW = $clog2(NUM_SOURCES + 1);
	localparam int CW  = $clog2(LIST_DEPTH + 1);
	localparam int AW  = $clog2(NUM_SOURCES * LIST_DEPTH);
	localparam int EW  = OFF_W + LEN_W;
	localparam int MW  = NUM_SOURCES * LIST_DEPTH;

	logic [CW-1:0]    cnt_q  [NUM_SOURCES];
	logic [CW-1:0]    rp_q   [NUM_SOURCES];
	logic [PW-1:0]    slot_q [NUM_SOURCES];
	logic [SZW-1:0]   size_q;
	logic [PW-1:0]    scan_q;
	logic [SZW-1:0]   bi_q;
	logic [PW-1:0]    k_q;
	logic [PW-1:0]    m_q;
	logic [OFF_W-1:0] keym_q;
	logic [EW-1:0]    mem    [MW];
	logic [EW-1:0]    rd_q;
	logic [OFF_W-1:0] res_off_q;
	logic [LEN_W-1:0] res_len_q;
	logic [SRC_W-1:0] res_src_q;
	logic             out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic             out_last_q;
	logic             out_user_q;

	logic [PW+1:0]    l_w;
	logic [PW+1:0]    r_w;
	logic [PW-1:0]    rpos;
	logic [PW-1:0]    rd_src;
	logic [AW-1:0]    raddr;
	logic [PW-1:0]    ld_idx;
	logic             ld_ok;
	logic [AW-1:0]    waddr;
	logic [OFF_W-1:0] rd_key;
	logic [PW-1:0]    s0;
	logic [CW-1:0]    rp_inc;
	logic [SZW-1:0]   size_dec;

	assign l_w    = (PW+2)'({k_q, 1'b1});
	assign r_w    = l_w + (PW+2)'(1);
	assign rd_key = rd_q[OFF_W-1:0];
	assign s0     = slot_q[0];
	assign rp_inc = rp_q[s0] + CW'(1);
	assign size_dec = size_q - SZW'(1);

	always_comb begin
		if (cmd.rd_l)
			rpos = l_w[PW-1:0];
		else if (cmd.rd_r)
			rpos = r_w[PW-1:0];
		else if (cmd.pop_rd)
			rpos = '0;
		else
			rpos = k_q;
	end

	assign rd_src = slot_q[rpos];
	assign raddr  = AW'(rd_src) * AW'(LIST_DEPTH) + AW'(rp_q[rd_src]);

	assign ld_idx = PW'(in_source);
	assign ld_ok  = cmd.load && (32'(in_source) < NUM_SOURCES)
		&& (cnt_q[ld_idx] < CW'(LIST_DEPTH));
	assign waddr  = AW'(ld_idx) * AW'(LIST_DEPTH) + AW'(cnt_q[ld_idx]);

	always_ff @(posedge clk) begin
		if (ld_ok)
			mem[waddr] <= {in_length, in_offset};
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SOURCES; i++) begin
				cnt_q[i]  <= '0;
				rp_q[i]   <= '0;
				slot_q[i] <= '0;
			end
			size_q <= '0;
			scan_q <= '0;
			bi_q   <= '0;
			k_q    <= '0;
			m_q    <= '0;
		end else begin
			if (ld_ok)
				cnt_q[ld_idx] <= cnt_q[ld_idx] + CW'(1);
			if (cmd.scan_init) begin
				scan_q <= '0;
				size_q <= '0;
			end
			if (cmd.scan_step) begin
				scan_q <= scan_q + PW'(1);
				if (cnt_q[scan_q] > rp_q[scan_q]) begin
					slot_q[size_q[PW-1:0]] <= scan_q;
					size_q <= size_q + SZW'(1);
				end
			end
			if (cmd.build_init)
				bi_q <= size_q >> 1;
			if (cmd.bi_dec)
				bi_q <= bi_q - SZW'(1);
			if (cmd.sift_init_build)
				k_q <= PW'(bi_q - SZW'(1));
			if (cmd.cap_k)
				m_q <= k_q;
			if (cmd.cmp_l && rd_key < keym_q)
				m_q <= l_w[PW-1:0];
			if (cmd.cmp_r && rd_key < keym_q)
				m_q <= r_w[PW-1:0];
			if (cmd.swap) begin
				slot_q[k_q] <= slot_q[m_q];
				slot_q[m_q] <= slot_q[k_q];
				k_q <= m_q;
			end
			if (cmd.pop_cap) begin
				k_q <= '0;
				if (rp_inc >= cnt_q[s0]) begin
					rp_q[s0]  <= '0;
					cnt_q[s0] <= '0;
					slot_q[0] <= slot_q[size_dec[PW-1:0]];
					size_q    <= size_dec;
				end else begin
					rp_q[s0] <= rp_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_k)
			keym_q <= rd_key;
		if ((cmd.cmp_l || cmd.cmp_r) && rd_key < keym_q)
			keym_q <= rd_key;
		if (cmd.pop_cap) begin
			res_off_q <= rd_q[OFF_W-1:0];
			res_len_q <= rd_q[EW-1:OFF_W];
			res_src_q <= SRC_W'(s0);
		end
		if (cmd.emit) begin
			out_data_q <= DATA_W'({res_src_q, res_len_q, res_off_q});
			out_last_q <= (size_q == '0);
			out_user_q <= 1'b0;
		end
		if (cmd.emit_empty) begin
			out_data_q <= '0;
			out_last_q <= 1'b0;
			out_user_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit || cmd.emit_empty)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_user_q;

	assign sts.scan_last = (scan_q == PW'(NUM_SOURCES - 1));
	assign sts.bi_zero   = (bi_q == '0);
	assign sts.l_ok      = (l_w < (PW+2)'(size_q));
	assign sts.r_ok      = (r_w < (PW+2)'(size_q));
	assign sts.m_is_k    = (m_q == k_q);
	assign sts.size_zero = (size_q == '0);
	assign sts.out_busy  = out_valid_q && !m_tready;

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(size_q) <= NUM_SOURCES)
		else $error("heap size above source count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0 && !m_tlast)
		else $error("empty word carries data");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.emit_empty) |-> !sts.out_busy)
		else $error("output overwritten while stalled");

endmodule

/* hw/rtl/kwhm_ctrl.sv */
// Controller of the k-way heap merge core: sequences load, heap build,
// sift-down and pop through command words to the datapath.
// Depends on kwhm_pkg.
module kwhm_ctrl import kwhm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [MODE_W-1:0] mode,
	input  kwhm_sts_t         sts,
	output kwhm_cmd_t         cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SCAN  = 4'd1;
	localparam logic [3:0] ST_BINIT = 4'd2;
	localparam logic [3:0] ST_BSIFT = 4'd3;
	localparam logic [3:0] ST_SK    = 4'd4;
	localparam logic [3:0] ST_SKW   = 4'd5;
	localparam logic [3:0] ST_SLW   = 4'd6;
	localparam logic [3:0] ST_SRW   = 4'd7;
	localparam logic [3:0] ST_SSWAP = 4'd8;
	localparam logic [3:0] ST_PRD   = 4'd9;
	localparam logic [3:0] ST_PCAP  = 4'd10;
	localparam logic [3:0] ST_EMIT  = 4'd11;
	localparam logic [3:0] ST_EMPTY = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       build_q;
	logic       build_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		build_d = build_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (mode)
						MODE_LOAD: cmd.load = 1'b1;
						MODE_START: begin
							cmd.scan_init = 1'b1;
							build_d = 1'b1;
							state_d = ST_SCAN;
						end
						MODE_POP: begin
							build_d = 1'b0;
							state_d = sts.size_zero ? ST_EMPTY : ST_PRD;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last)
					state_d = ST_BINIT;
			end
			ST_BINIT: begin
				cmd.build_init = 1'b1;
				state_d = ST_BSIFT;
			end
			ST_BSIFT: begin
				if (sts.bi_zero) begin
					state_d = ST_IDLE;
				end else begin
					cmd.sift_init_build = 1'b1;
					state_d = ST_SK;
				end
			end
			ST_SK: begin
				if (sts.l_ok) begin
					cmd.rd_k = 1'b1;
					state_d = ST_SKW;
				end else if (build_q) begin
					cmd.bi_dec = 1'b1;
					state_d = ST_BSIFT;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SKW: begin
				cmd.cap_k = 1'b1;
				cmd.rd_l = 1'b1;
				state_d = ST_SLW;
			end
			ST_SLW: begin
				cmd.cmp_l = 1'b1;
				if (sts.r_ok) begin
					cmd.rd_r = 1'b1;
					state_d = ST_SRW;
				end else begin
					state_d = ST_SSWAP;
				end
			end
			ST_SRW: begin
				cmd.cmp_r = 1'b1;
				state_d = ST_SSWAP;
			end
			ST_SSWAP: begin
				if (!sts.m_is_k) begin
					cmd.swap = 1'b1;
					state_d = ST_SK;
				end else if (build_q) begin
					cmd.bi_dec = 1'b1;
					state_d = ST_BSIFT;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_PRD: begin
				cmd.pop_rd = 1'b1;
				state_d = ST_PCAP;
			end
			ST_PCAP: begin
				cmd.pop_cap = 1'b1;
				state_d = ST_SK;
			end
			ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				if (!sts.out_busy) begin
					cmd.emit_empty = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			build_q <= 1'b0;
		end else begin
			state_q <= state_d;
			build_q <= build_d;
		end
	end

endmodule

/* hw/rtl/kway_heap_merge_core.sv */
// Top level of the k-way heap merge core: joins controller and datapath.
// Depends on kwhm_pkg, kwhm_ctrl, kwhm_datapath.
//
// Input words (s_*): s_tuser is the kind: load, start or pop. A load
// appends (offset, length) to a source list without leaving idle;
// loads into a full list or an absent source are dropped. A start builds
// the min-heap: a scan of every source, a setup step, then a
// sift-down for each inner node. A pop emits the smallest head element
// on m_*, advances that list and sifts the root down. Its steps are
// accept, head read and capture; for each heap node compared on the way
// down a read of it and its children, the compares and a swap where needed;
// a check when the walk ends at a leaf; and the emit. Each sift level is set
// by the single read port of the element memory, one head key read per cycle.
// Only one word is worked on at a time; s_tready is high while idle.
// Results leave through an output register, so the next word is taken
// while a result waits; a pop finishing while m_tready is low holds
// until the register frees. m_tlast marks the pop that emptied the heap,
// m_tuser marks a pop on an empty heap with zero data.
// Reset clears all lists and the heap; element storage needs no clearing.
module kway_heap_merge_core import kwhm_pkg::*; #(
	parameter int NUM_SOURCES = DEF_NUM_SOURCES,
	parameter int LIST_DEPTH  = DEF_LIST_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,  // source[2:0], offset[65:3], length[97:66]
	input  logic [MODE_W-1:0] s_tuser,  // mode[1:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,  // out_offset[62:0], out_length[94:63], out_source[97:95]
	output logic              m_tlast,
	output logic              m_tuser   // empty_res
);

	kwhm_cmd_t cmd;
	kwhm_sts_t sts;

	kwhm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	kwhm_datapath #(
		.NUM_SOURCES (NUM_SOURCES),
		.LIST_DEPTH  (LIST_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_source (s_tdata[SRC_W-1:0]),
		.in_offset (s_tdata[SRC_W+OFF_W-1:SRC_W]),
		.in_length (s_tdata[SRC_W+OFF_W+LEN_W-1:SRC_W+OFF_W]),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

/* tb/sv/tb_kway_heap_merge_core.sv */
`timescale 1ns / 1ps
// Testbench for kway_heap_merge_core: loads, heap builds and pops against a merge predictor.
// Depends on kwhm_pkg and the RTL of the core.
module tb_kway_heap_merge_core;
	import kwhm_pkg::*;

	localparam int NSRC  = DEF_NUM_SOURCES;
	localparam int DEPTH = DEF_LIST_DEPTH;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SRC_W-1:0]  src;
		logic [OFF_W-1:0]  off;
		logic [LEN_W-1:0]  len;
	} word_t;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [LEN_W-1:0] len;
		logic [SRC_W-1:0] src;
		logic             is_last;
		logic             is_empty;
	} merged_t;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, m_tready = 0;
	logic [DATA_W-1:0] s_tdata = '0;
	logic [MODE_W-1:0] s_tuser = '0;
	logic s_tready, m_tvalid, m_tlast, m_tuser;
	logic [DATA_W-1:0] m_tdata;

	kway_heap_merge_core dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	logic [OFF_W-1:0] mem_off [NSRC*DEPTH];
	logic [LEN_W-1:0] mem_len [NSRC*DEPTH];
	int cnt [NSRC];
	int rdp [NSRC];
	int slot [NSRC];
	int hsize;

	word_t   pending [$];
	merged_t merged_q [$];
	int errors, pops_seen, empties_seen, words_sent, idle_cycles;
	bit hold_tx;

	function automatic logic [OFF_W-1:0] key_at(int pos);
		int r;
		r = rdp[slot[pos]];
		if (r >= DEPTH) r = DEPTH - 1;
		return mem_off[slot[pos]*DEPTH + r];
	endfunction

	function automatic void sift(int k);
		int l, r, m, t;
		forever begin
			l = 2*k + 1;
			r = 2*k + 2;
			m = k;
			if (l < hsize && key_at(l) < key_at(k)) m = l;
			if (r < hsize && key_at(r) < key_at(m)) m = r;
			if (m == k) return;
			t = slot[k]; slot[k] = slot[m]; slot[m] = t;
			k = m;
		end
	endfunction

	function automatic void merge_step(word_t w);
		merged_t e;
		int s, idx;
		e = '0;
		case (w.mode)
		MODE_LOAD: begin
			s = w.src;
			if (s < NSRC && cnt[s] < DEPTH) begin
				mem_off[s*DEPTH + cnt[s]] = w.off;
				mem_len[s*DEPTH + cnt[s]] = w.len;
				cnt[s]++;
			end
		end
		MODE_START: begin
			hsize = 0;
			for (int i = 0; i < NSRC; i++)
				if (cnt[i] > rdp[i]) slot[hsize++] = i;
			for (int i = hsize/2; i > 0; i--) sift(i - 1);
		end
		MODE_POP: begin
			if (hsize == 0) begin
				e.is_empty = 1;
			end else begin
				s = slot[0];
				idx = s*DEPTH + (rdp[s] >= DEPTH ? DEPTH - 1 : rdp[s]);
				e.off = mem_off[idx];
				e.len = mem_len[idx];
				e.src = SRC_W'(s);
				rdp[s]++;
				if (rdp[s] >= cnt[s]) begin
					rdp[s] = 0;
					cnt[s] = 0;
					slot[0] = slot[hsize-1];
					hsize--;
				end
				sift(0);
				e.is_last = (hsize == 0);
			end
			merged_q.push_back(e);
		end
		default: ;
		endcase
	endfunction

	task automatic report(string what, logic [127:0] got, logic [127:0] want);
		errors++;
		$display("mismatch %s: got %0h want %0h", what, got, want);
	endtask

	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// driver
	int tx_gap;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				merge_step(word_t'({s_tuser, s_tdata[2:0], s_tdata[65:3], s_tdata[97:66]}));
				words_sent++;
			end
			if ((s_tvalid && s_tready) || !s_tvalid) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 0;
				end else if (pending.size() > 0 && !hold_tx) begin
					word_t w;
					w = pending.pop_front();
					s_tvalid <= 1;
					s_tuser  <= w.mode;
					s_tdata  <= {6'd0, w.len, w.off, w.src};
					tx_gap = gap_len();
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// monitor
	int rx_gap;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				merged_t e;
				if (merged_q.size() == 0) begin
					errors++;
					$display("unexpected word: %0h", m_tdata);
				end else begin
					e = merged_q.pop_front();
					if (e.is_empty) empties_seen++; else pops_seen++;
					if (m_tdata[62:0] !== e.off) report("offset", m_tdata[62:0], e.off);
					if (m_tdata[94:63] !== e.len) report("length", m_tdata[94:63], e.len);
					if (m_tdata[97:95] !== e.src) report("source", m_tdata[97:95], e.src);
					if (m_tlast !== e.is_last) report("last", m_tlast, e.is_last);
					if (m_tuser !== e.is_empty) report("empty", m_tuser, e.is_empty);
				end
			end
			if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
				if ($urandom_range(3) == 0) rx_gap = gap_len();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n ||
		    (pending.size() == 0 && merged_q.size() == 0 && !hold_tx))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic word_t mk(logic [MODE_W-1:0] m, int s, logic [OFF_W-1:0] o,
	                             logic [LEN_W-1:0] l);
		word_t w;
		w.mode = m; w.src = SRC_W'(s); w.off = o; w.len = l;
		return w;
	endfunction

	function automatic logic [OFF_W-1:0] rnd_off();
		return {$urandom, $urandom} >> 1;
	endfunction

	// sorted runs of loads into random sources, a start, then mostly pops mixed with loads, starts and unknown-mode words
	task automatic add_merge(int nsrc_max, int len_max, bit small_keys);
		int n, k, b;
		logic [OFF_W-1:0] o;
		n = $urandom_range(nsrc_max, 1);
		for (int s = 0; s < n; s++) begin
			b = $urandom_range(NSRC-1);
			k = $urandom_range(len_max, 1);
			o = small_keys ? OFF_W'($urandom_range(4)) : rnd_off() >> $urandom_range(8);
			for (int j = 0; j < k; j++) begin
				pending.push_back(mk(MODE_LOAD, b, o, $urandom));
				o = o + (small_keys ? OFF_W'($urandom_range(2)) : OFF_W'($urandom_range(1000)));
			end
		end
		pending.push_back(mk(MODE_START, $urandom_range(7), rnd_off(), $urandom));
		k = $urandom_range(12, 2);
		for (int j = 0; j < k; j++) begin
			b = $urandom_range(99);
			if (b < 80) pending.push_back(mk(MODE_POP, $urandom_range(7), rnd_off(), $urandom));
			else if (b < 90) pending.push_back(mk(MODE_LOAD, $urandom_range(7), rnd_off(),
			                                    $urandom));
			else if (b < 95) pending.push_back(mk(MODE_START, 0, 0, 0));
			else pending.push_back(mk(2'd3, $urandom_range(7), rnd_off(), $urandom));
		end
	endtask

	task automatic drain();
		wait (pending.size() == 0);
		repeat (2) @(posedge clk);
		wait (!s_tvalid && merged_q.size() == 0);
	endtask

	initial begin
		for (int i = 0; i < NSRC*DEPTH; i++) begin
			mem_off[i] = '0; mem_len[i] = '0;
		end
		for (int i = 0; i < NSRC; i++) begin
			cnt[i] = 0; rdp[i] = 0; slot[i] = 0;
		end
		hsize = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// directed: empty pop, extremes, ties, unknown mode, full list, reload
		pending.push_back(mk(MODE_POP, 0, 0, 0));
		pending.push_back(mk(MODE_START, 7, '1, '1));
		pending.push_back(mk(MODE_POP, 7, '1, '1));
		pending.push_back(mk(2'd3, 5, '1, '1));
		pending.push_back(mk(MODE_LOAD, 7, '1, '1));
		pending.push_back(mk(MODE_LOAD, 0, '0, '0));
		pending.push_back(mk(MODE_LOAD, 3, 63'd5, 32'h5555_aaaa));
		pending.push_back(mk(MODE_LOAD, 4, 63'd5, 32'haaaa_5555));
		pending.push_back(mk(MODE_LOAD, 4, 63'd9, 32'd1));
		pending.push_back(mk(MODE_START, 0, 0, 0));
		pending.push_back(mk(MODE_POP, 0, 0, 0));
		pending.push_back(mk(MODE_LOAD, 0, 63'd2, 32'd2));
		pending.push_back(mk(MODE_START, 0, 0, 0));
		for (int i = 0; i < 6; i++) pending.push_back(mk(MODE_POP, 0, 0, 0));
		drain();
		for (int i = 0; i < DEPTH + 2; i++)
			pending.push_back(mk(MODE_LOAD, 6, OFF_W'(i), LEN_W'(i)));
		pending.push_back(mk(MODE_START, 0, 0, 0));
		for (int i = 0; i < DEPTH + 1; i++) pending.push_back(mk(MODE_POP, 0, 0, 0));
		drain();

		while (words_sent < 1050) begin
			add_merge(NSRC, $urandom_range(3) == 0 ? 8 : 3, $urandom_range(1));
			if ($urandom_range(9) == 0) begin
				hold_tx = 1;
				wait (!s_tvalid && merged_q.size() == 0);
				hold_tx = 0;
			end
			wait (pending.size() < 4);
		end
		drain();
		hold_tx = 1;
		for (int i = 0; i < NSRC; i++)
			if (cnt[i] > 0) begin
				pending.push_back(mk(MODE_START, 0, 0, 0));
				break;
			end
		hold_tx = 0;
		drain();
		repeat (200) @(posedge clk);
		$display("sent %0d words, checked %0d merged elements and %0d empty pops",
		         words_sent, pops_seen, empties_seen);
		if (errors == 0 && merged_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, merged_q.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
